// ===== rtl/sstf_pkg.sv =====
// Shared types, segment constants and the hex glyph table for the
// seven-segment tenths formatter. No dependencies.

package sstf_pkg;

  localparam int unsigned InW   = 16;
  localparam int unsigned SegW  = 8;
  localparam int unsigned MagW  = 11;  // shown magnitude never exceeds 2000
  localparam int unsigned DigW  = 4;

  localparam logic signed [InW-1:0] HiLimit   = 16'sd19995;
  localparam logic signed [InW-1:0] LoLimit   = -16'sd995;
  localparam logic signed [InW-1:0] WholeHi   = 16'sd1995;
  localparam logic signed [InW-1:0] WholeLo   = -16'sd95;

  localparam logic [SegW-1:0] SegPoint = 8'h08;
  localparam logic [SegW-1:0] SegOne   = 8'h08;
  localparam logic [SegW-1:0] SegMinus = 8'h02;
  localparam logic [SegW-1:0] SegZero  = 8'hF5;
  localparam logic [SegW-1:0] SegH     = 8'h67;
  localparam logic [SegW-1:0] SegI     = 8'h40;
  localparam logic [SegW-1:0] SegL     = 8'hE0;
  localparam logic [SegW-1:0] SegO     = 8'hC6;

  typedef enum logic [1:0] {
    MODE_NUM,
    MODE_HI,
    MODE_LO
  } mode_e;

  // Classified value handed from the magnitude stage to the segment stage
  typedef struct packed {
    mode_e             mode;
    logic              neg;
    logic              point;
    logic [MagW-1:0]   mag;
  } mag_t;

  typedef struct packed {
    logic [SegW-1:0] hund;
    logic [SegW-1:0] tens;
    logic [SegW-1:0] ones;
  } segs_t;

  function automatic logic [SegW-1:0] glyph(input logic [DigW-1:0] d);
    logic [SegW-1:0] g;
    case (d)
      4'h0:    g = 8'hF5;
      4'h1:    g = 8'h05;
      4'h2:    g = 8'hD3;
      4'h3:    g = 8'h97;
      4'h4:    g = 8'h27;
      4'h5:    g = 8'hB6;
      4'h6:    g = 8'hF6;
      4'h7:    g = 8'h15;
      4'h8:    g = 8'hF7;
      4'h9:    g = 8'hB7;
      4'hA:    g = 8'h77;
      4'hB:    g = 8'hE6;
      4'hC:    g = 8'hF0;
      4'hD:    g = 8'hC7;
      4'hE:    g = 8'hF2;
      default: g = 8'h72;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/sstf_mag.sv =====
// Range check, sign split and optional round-to-whole of the input value.
// Depends on sstf_pkg.

module sstf_mag
  import sstf_pkg::*;
(
  input  logic [InW-1:0] value_i,
  output mag_t           mag_o
);

  logic signed [InW-1:0] v;
  logic [InW-1:0]        abs_v;
  logic [InW:0]          rnd;      // abs + 5, up to 17 bits
  logic [InW+19:0]       prod;     // rnd * 52429
  logic [InW:0]          whole;
  logic                  is_whole;

  always_comb begin
    v        = signed'(value_i);
    abs_v    = v[InW-1] ? InW'(-v) : value_i;
    rnd      = {1'b0, abs_v} + (InW+1)'(5);
    // exact divide by 10 for values below 2**16 + a few
    prod     = (InW+20)'(rnd) * (InW+20)'(52429);
    whole    = prod[InW+19:19];
    is_whole = (v > WholeHi) || (v < WholeLo);

    mag_o.neg   = v[InW-1];
    mag_o.point = !is_whole;
    mag_o.mag   = is_whole ? whole[MagW-1:0] : abs_v[MagW-1:0];
    if (v > HiLimit) begin
      mag_o.mode = MODE_HI;
    end else if (v < LoLimit) begin
      mag_o.mode = MODE_LO;
    end else begin
      mag_o.mode = MODE_NUM;
    end
  end

endmodule

// ===== rtl/sstf_seg.sv =====
// Decimal digit split of the shown magnitude and segment byte assembly.
// Depends on sstf_pkg (glyph table, segment constants).

module sstf_seg
  import sstf_pkg::*;
(
  input  mag_t  mag_i,
  output segs_t segs_o
);

  localparam int unsigned PW = 24;

  logic [PW-1:0]   p10, p100;
  logic [7:0]      q10;    // mag / 10, up to 200
  logic [4:0]      q100;   // mag / 100, up to 20
  logic [DigW-1:0] d_one, d_ten, d_hun;
  logic [SegW-1:0] hund, tens;

  always_comb begin
    // x * 6554 >> 16 is exact divide by 10 below 16384
    p10   = PW'(mag_i.mag) * PW'(6554);
    p100  = PW'(mag_i.mag) * PW'(5243);
    q10   = p10[23:16];
    q100  = p100[23:19];
    d_one = DigW'(mag_i.mag - (MagW'(q10) << 3) - (MagW'(q10) << 1));
    d_ten = DigW'(q10 - (8'(q100) << 3) - (8'(q100) << 1));
    if (q100 >= 5'd20) begin
      d_hun = DigW'(q100 - 5'd20);
    end else if (q100 >= 5'd10) begin
      d_hun = DigW'(q100 - 5'd10);
    end else begin
      d_hun = DigW'(q100);
    end

    hund = mag_i.neg ? SegMinus : '0;
    tens = mag_i.point ? SegPoint : '0;
    if (mag_i.mag > MagW'(999)) hund = hund | SegOne;
    if (mag_i.mag > MagW'(99))  hund = hund | glyph(d_hun);
    if (mag_i.mag > MagW'(9)) begin
      tens = tens | glyph(d_ten);
    end else begin
      tens = tens | SegZero;
    end

    case (mag_i.mode)
      MODE_HI: begin
        segs_o.ones = '0;
        segs_o.tens = SegI;
        segs_o.hund = SegH;
      end
      MODE_LO: begin
        segs_o.ones = '0;
        segs_o.tens = SegO;
        segs_o.hund = SegL;
      end
      default: begin
        segs_o.ones = glyph(d_one);
        segs_o.tens = tens;
        segs_o.hund = hund;
      end
    endcase
  end

endmodule

// ===== rtl/seven_segment_tenths_formatter.sv =====
// Top level of the seven-segment tenths formatter: three-register pipeline
// around sstf_mag and sstf_seg. Depends on sstf_pkg.
//
// Usage
//   Slave stream: one word per value, tdata[15:0] = value_tenths (signed,
//   units of 0.1). Master stream: one word per value, tdata[23:0] holds the
//   three LCD segment bytes, ones digit lowest.
//   Values above 1999.5 read "Hi", below -99.5 read "Lo"; 199.6 up and
//   -9.6 down are rounded to whole units with no point; the rest show
//   tenths with the decimal point lit.
// Timing
//   Input register, magnitude register, result register, in that order.
//   One word per cycle is sustained while the receiver does not stall;
//   the stage logic is one 17x16 constant multiply (round/10) and then
//   two parallel 11-bit constant multiplies (digit split) plus glyph
//   lookups. The result register drives the output word and its valid.
// Stall / reset
//   The whole pipe moves when the result register is empty or being
//   taken; a stalled receiver freezes all stages and drops s_axis_tready.
//   Reset clears the stage valid flags only; the pipe comes up empty.

module seven_segment_tenths_formatter
  import sstf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InW-1:0]       s_axis_tdata,   // [15:0] value_tenths
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [3*SegW-1:0]    m_axis_tdata    // [7:0] ones, [15:8] tens, [23:16] hundreds
);

  logic           adv;
  logic           in_vld_q, mid_vld_q, out_vld_q;
  logic [InW-1:0] in_q;
  mag_t           mag_d, mag_q;
  segs_t          segs_d, segs_q;

  // pipe moves unless the result word is stuck
  assign adv = !out_vld_q || m_axis_tready;

  sstf_mag u_mag (
    .value_i (in_q),
    .mag_o   (mag_d)
  );

  sstf_seg u_seg (
    .mag_i  (mag_q),
    .segs_o (segs_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q  <= s_axis_tvalid;
      mid_vld_q <= in_vld_q;
      out_vld_q <= mid_vld_q;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q   <= s_axis_tdata;
      mag_q  <= mag_d;
      segs_q <= segs_d;
    end
  end

  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {segs_q.hund, segs_q.tens, segs_q.ones};

endmodule

// ===== rtl/sstf_checker.sv =====
// Port-level checks for the seven-segment tenths formatter, bound to the
// top level. Standalone; no package needed.

module sstf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // stuck result must stop the input side
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while result stalled");

  // blank ones digit only for Hi or Lo
  a_hilo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[7:0] == 8'h00) |->
      ((m_axis_tdata[15:8] == 8'h40) && (m_axis_tdata[23:16] == 8'h67)) ||
      ((m_axis_tdata[15:8] == 8'hC6) && (m_axis_tdata[23:16] == 8'hE0)))
    else $error("bad Hi/Lo pattern");

  // empty pipe out of reset
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind seven_segment_tenths_formatter sstf_checker u_sstf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/tb_top.sv =====
// Self-checking bench for seven_segment_tenths_formatter: directed, random and stall tests
// with an in-bench segment predictor and a scoreboard of expected segment bytes.
// Depends on sstf_pkg and the formatter RTL.
`timescale 1ns / 100ps

module tb_top;
  import sstf_pkg::*;

  localparam int ClkHalf    = 5;
  localparam int CycleLimit = 300000;
  localparam int LongHold   = 200;

  // Digit glyphs 0..9; the shown magnitude never exceeds 2000, so every
  // digit after the decimal split is below ten.
  localparam logic [SegW-1:0] DigitSegs [10] = '{
    8'hF5, 8'h05, 8'hD3, 8'h97, 8'h27, 8'hB6, 8'hF6, 8'h15, 8'hF7, 8'hB7
  };

  // Values next to the display thresholds and digit-count changes
  localparam int EdgeVals [8] = '{19995, -995, 1995, -95, 0, 99, 999, 19990};

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InW-1:0]      s_axis_tdata;   // [15:0] value_tenths
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [3*SegW-1:0]   m_axis_tdata;   // [7:0] ones, [15:8] tens, [23:16] hundreds

  segs_t pending_segs[$];  // predicted displays, oldest first
  int    failures       = 0;
  int    words_sent     = 0;
  int    words_checked  = 0;
  int    directed_words = 0;
  int    long_holds     = 0;
  int    cycle_count    = 0;
  int    hold_request   = 0;  // set by a test, picked up by the receiver
  bit    src_idle_en    = 1'b1;
  bit    snk_idle_en    = 1'b1;

  seven_segment_tenths_formatter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #ClkHalf;
    clk_i = 1'b0;
    #ClkHalf;
  end

  // Predicted segment bytes for one signed tenths value.
  function automatic segs_t format_tenths(input logic signed [InW-1:0] value);
    int    v;
    int    mag;
    segs_t s;
    v = value;
    s = '0;
    if (v > HiLimit) begin
      s.tens = SegI;
      s.hund = SegH;
    end else if (v < LoLimit) begin
      s.tens = SegO;
      s.hund = SegL;
    end else begin
      mag    = (v < 0) ? -v : v;
      s.hund = (v < 0) ? SegMinus : '0;
      // Outside the tenths window the value is rounded to whole units
      if (v > WholeHi || v < WholeLo) begin
        s.tens = '0;
        mag    = (mag + 5) / 10;
      end else begin
        s.tens = SegPoint;
      end
      // 1000..2000 light the leading one; 2000 itself reads as 1000
      if (mag > 999) s.hund |= SegOne;
      if (mag > 99) s.hund |= DigitSegs[(mag / 100) % 10];
      if (mag > 9) begin
        s.tens |= DigitSegs[(mag / 10) % 10];
      end else begin
        s.tens |= SegZero;  // small magnitude keeps a zero in the middle digit
      end
      s.ones = DigitSegs[mag % 10];
    end
    return s;
  endfunction

  function automatic void check_byte(input string name, input logic [SegW-1:0] want,
                                     input logic [SegW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %02h, got %02h", name, want, got);
      failures++;
    end
  endfunction

  // Scoreboard: outputs are compared first, then the accepted input word is
  // predicted; a word in at this edge cannot leave at the same edge.
  always @(posedge clk_i) begin : scoreboard
    segs_t want;
    segs_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = segs_t'(m_axis_tdata);
        if (pending_segs.size() == 0) begin
          $error("result %06h arrived with no word outstanding", m_axis_tdata);
          failures++;
        end else begin
          want = pending_segs.pop_front();
          check_byte("ones_segments", want.ones, got.ones);
          check_byte("tens_segments", want.tens, got.tens);
          check_byte("hundreds_segments", want.hund, got.hund);
          words_checked++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_segs.push_back(format_tenths(s_axis_tdata));
        words_sent++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding",
               cycle_count, pending_segs.size());
      $display("seven_segment_tenths_formatter test failed");
      $finish;
    end
  end

  // Receiver: per word a random hold-off, or a long one when a test asks.
  initial begin : receiver
    int wait_cycles;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        wait_cycles  = hold_request;
        hold_request = 0;
        long_holds++;
      end else begin
        wait_cycles = snk_idle_en ? $urandom_range(0, 14) : 0;
      end
      if (wait_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Offer one word after a random gap and hold it until accepted. Valid is
  // left high so back-to-back words need no second assignment in one step.
  task automatic send_value(input logic [InW-1:0] word);
    int gap;
    @(negedge clk_i);
    gap = src_idle_en ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  function automatic logic [InW-1:0] draw_value();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 65535);             // whole input range
      4, 5, 6:    v = -95 + int'($urandom_range(0, 2090));  // tenths window
      7, 8: begin                                           // whole-unit window
        if ($urandom_range(0, 1)) v = 1996 + int'($urandom_range(0, 17999));
        else v = -995 + int'($urandom_range(0, 899));
      end
      default:    v = EdgeVals[$urandom_range(0, 7)] + int'($urandom_range(0, 6)) - 3;
    endcase
    return v[InW-1:0];
  endfunction

  // Thresholds, rounding edge, small magnitudes and the input extremes.
  task automatic test_boundaries();
    int vals [] = '{-32768, 32767, 19996, 19995, 19991, 19990, 19985, 1996, 1995,
                    1000, 999, 100, 99, 10, 9, 0, -1, -9, -10, -95, -96, -99,
                    -995, -996, -1000};
    foreach (vals[i]) begin
      send_value(vals[i][InW-1:0]);
      directed_words++;
    end
  endtask

  // Random values in blocks; some blocks run with one or both sides never idle.
  task automatic test_random_mix(input int n_words);
    for (int i = 0; i < n_words; i++) begin
      if (i % 100 == 0) begin
        src_idle_en = ($urandom_range(0, 3) != 0);
        snk_idle_en = ($urandom_range(0, 3) != 0);
      end
      send_value(draw_value());
    end
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
  endtask

  // Receiver stops for a long stretch while the sender keeps offering words,
  // so the pipe fills and the input side must stall.
  task automatic test_receiver_stall(input int n_words);
    src_idle_en  = 1'b0;
    hold_request = LongHold;
    for (int i = 0; i < n_words; i++) send_value(draw_value());
    src_idle_en = 1'b1;
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_boundaries();
    test_random_mix(830);
    test_receiver_stall(40);
    test_random_mix(30);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);  // catch any stray result past the pipe depth

    $display("%0d words sent (%0d directed), %0d results checked, %0d long receiver holds",
             words_sent, directed_words, words_checked, long_holds);
    $display("covered Hi/Lo, whole-unit rounding, tenths with point and random idling");
    if (failures == 0) begin
      $display("seven_segment_tenths_formatter test passed");
    end else begin
      $display("%0d mismatches", failures);
      $display("seven_segment_tenths_formatter test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sstf_pkg.sv
rtl/sstf_mag.sv
rtl/sstf_seg.sv
rtl/seven_segment_tenths_formatter.sv
rtl/sstf_checker.sv
bench/tb_top.sv
